// File: rtl/core/dnsle_pkg.sv
// ----------------------------------------------------------------------------
// dnsle_pkg
// shared types and constants of the dns name label encoder
// ----------------------------------------------------------------------------
package dnsle_pkg;

    localparam int BYTE_W = 8;
    localparam logic [BYTE_W-1:0] DOT_CHAR = 8'h2E;
    localparam logic [BYTE_W-1:0] ROOT_BYTE = 8'h00;
    localparam logic [BYTE_W-1:0] MAX_BYTES_RESET = 8'd255;

    // input item kinds
    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_END  = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEN,
        S_RD,
        S_CHR,
        S_ROOT
    } seq_state_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
        logic              overflow;
    } out_item_t;

endpackage

// File: rtl/core/dnsle_label_ram.sv
// ----------------------------------------------------------------------------
// dnsle_label_ram
// label character buffer, one write and one registered read port
// ----------------------------------------------------------------------------
module dnsle_label_ram
    import dnsle_pkg::*;
#(
    parameter int DEPTH = 62,
    parameter int AW    = 6
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [AW-1:0]     wr_addr,
    input  logic [BYTE_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [AW-1:0]     rd_addr,
    output logic [BYTE_W-1:0] rd_data
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/dnsle_out_reg.sv
// ----------------------------------------------------------------------------
// dnsle_out_reg
// output register between the sequencer and the result stream
// ----------------------------------------------------------------------------
module dnsle_out_reg
    import dnsle_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  out_item_t         in_item,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,
    output logic              m_tlast,
    output logic [0:0]        m_tuser
);

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;

    assign in_ready = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= in_item;
        end
    end

    assign m_tvalid   = valid_reg;
    assign m_tdata    = item_reg.out_byte;
    assign m_tlast    = item_reg.last;
    assign m_tuser[0] = item_reg.overflow;

endmodule

// File: rtl/core/dnsle_seq.sv
// ----------------------------------------------------------------------------
// dnsle_seq
// label sequencer: buffers characters, reads the label back at a dot or end
// ----------------------------------------------------------------------------
module dnsle_seq
    import dnsle_pkg::*;
#(
    parameter int MAX_LABEL = 62,
    parameter int AW        = 6,
    parameter int LW        = 6
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              in_op,
    input  logic [BYTE_W-1:0] in_char,
    input  logic [BYTE_W-1:0] max_bytes,
    output logic              out_valid,
    input  logic              out_ready,
    output out_item_t         out_item,
    output logic              ram_wr_en,
    output logic [AW-1:0]     ram_wr_addr,
    output logic [BYTE_W-1:0] ram_wr_data,
    output logic              ram_rd_en,
    output logic [AW-1:0]     ram_rd_addr,
    input  logic [BYTE_W-1:0] ram_rd_data
);

    localparam logic [LW-1:0] MAX_LEN = LW'(MAX_LABEL);

    seq_state_t        state_reg, state_next;
    logic [LW-1:0]     len_reg, len_next;
    logic [LW-1:0]     idx_reg, idx_next;
    logic [BYTE_W-1:0] bytes_reg, bytes_next;
    logic              lovf_reg, lovf_next;
    logic              started_reg, started_next;
    logic              item_ovf_reg, item_ovf_next;
    logic              is_end_reg, is_end_next;

    logic accept;
    logic push;
    logic room;
    logic room_after;
    logic last_char;
    logic is_dot;

    assign accept     = in_valid && in_ready;
    assign push       = out_valid && out_ready;
    assign is_dot     = (in_char == DOT_CHAR);
    assign room       = (bytes_reg < max_bytes);
    assign room_after = ({1'b0, bytes_reg} + 9'd1) < {1'b0, max_bytes};
    assign last_char  = ((idx_reg + LW'(1)) == len_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (in_op == OP_END) begin
                        state_next = (started_reg && room) ? S_LEN : S_ROOT;
                    end else if (is_dot && room) begin
                        state_next = S_LEN;
                    end
                end
            end
            S_LEN: begin
                if (push) begin
                    if (len_reg != '0 && room_after) begin
                        state_next = S_RD;
                    end else begin
                        state_next = is_end_reg ? S_ROOT : S_IDLE;
                    end
                end
            end
            S_RD: begin
                state_next = S_CHR;
            end
            S_CHR: begin
                if (push) begin
                    if (!last_char && room_after) begin
                        state_next = S_RD;
                    end else begin
                        state_next = is_end_reg ? S_ROOT : S_IDLE;
                    end
                end
            end
            S_ROOT: begin
                if (push) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        in_ready          = 1'b0;
        out_valid         = 1'b0;
        out_item.out_byte = ROOT_BYTE;
        out_item.last     = 1'b0;
        out_item.overflow = item_ovf_reg;
        ram_wr_en         = 1'b0;
        ram_wr_addr       = len_reg[AW-1:0];
        ram_wr_data       = in_char;
        ram_rd_en         = 1'b0;
        ram_rd_addr       = idx_reg[AW-1:0];
        unique case (state_reg)
            S_IDLE: begin
                in_ready  = 1'b1;
                ram_wr_en = accept && (in_op == OP_CHAR) && !is_dot && (len_reg < MAX_LEN);
            end
            S_LEN: begin
                out_valid         = 1'b1;
                out_item.out_byte = BYTE_W'(len_reg);
                out_item.last     = !is_end_reg && (len_reg == '0 || !room_after);
            end
            S_RD: begin
                ram_rd_en = 1'b1;
            end
            S_CHR: begin
                out_valid         = 1'b1;
                out_item.out_byte = ram_rd_data;
                out_item.last     = !is_end_reg && (last_char || !room_after);
            end
            S_ROOT: begin
                out_valid     = 1'b1;
                out_item.last = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // label state
    always_comb begin
        len_next      = len_reg;
        idx_next      = idx_reg;
        bytes_next    = bytes_reg;
        lovf_next     = lovf_reg;
        started_next  = started_reg;
        item_ovf_next = item_ovf_reg;
        is_end_next   = is_end_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    item_ovf_next = lovf_reg;
                    is_end_next   = (in_op == OP_END);
                    idx_next      = '0;
                    if (in_op == OP_CHAR) begin
                        started_next = 1'b1;
                        if (!is_dot) begin
                            if (len_reg < MAX_LEN) begin
                                len_next = len_reg + LW'(1);
                            end else begin
                                lovf_next = 1'b1;
                            end
                        end else if (!room) begin
                            // limit reached: the label closes with no bytes
                            len_next  = '0;
                            lovf_next = 1'b0;
                        end
                    end
                end
            end
            S_LEN: begin
                if (push) begin
                    bytes_next = bytes_reg + BYTE_W'(1);
                    if (!(len_reg != '0 && room_after)) begin
                        len_next  = '0;
                        lovf_next = 1'b0;
                    end
                end
            end
            S_RD: begin
            end
            S_CHR: begin
                if (push) begin
                    bytes_next = bytes_reg + BYTE_W'(1);
                    if (!last_char && room_after) begin
                        idx_next = idx_reg + LW'(1);
                    end else begin
                        len_next  = '0;
                        lovf_next = 1'b0;
                    end
                end
            end
            S_ROOT: begin
                if (push) begin
                    len_next     = '0;
                    bytes_next   = '0;
                    lovf_next    = 1'b0;
                    started_next = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            len_reg     <= '0;
            bytes_reg   <= '0;
            lovf_reg    <= 1'b0;
            started_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            len_reg     <= len_next;
            bytes_reg   <= bytes_next;
            lovf_reg    <= lovf_next;
            started_reg <= started_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        item_ovf_reg <= item_ovf_next;
        is_end_reg   <= is_end_next;
    end

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= MAX_LEN)
        else $error("label length beyond buffer depth");

    a_rd_then_chr: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_RD |=> state_reg == S_CHR)
        else $error("buffer read not followed by character transfer");

    a_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && state_reg != S_ROOT) |-> room)
        else $error("label byte sent beyond byte limit");

    a_idx_in_label: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CHR |-> idx_reg < len_reg)
        else $error("character index outside current label");

    a_root_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && state_reg == S_ROOT) |=> (len_reg == '0 && !started_reg && bytes_reg == '0))
        else $error("name state not cleared after root byte");

endmodule

// File: rtl/core/dns_name_label_encoder_core.sv
// ----------------------------------------------------------------------------
// dns_name_label_encoder_core
// dotted host name in, dns wire labels out, one byte per transfer
// ----------------------------------------------------------------------------
// flow: a plain character is buffered and gives no result; a dot or end
//   goes through the sequencer state register and then the output register
//   to show its first byte; one character per cycle while buffering; a
//   closing label sends its length byte, then each buffered byte needs a
//   buffer read state and a transfer state, the root byte after that at an end
// reset: aresetn is synchronous, active low; control state and max_bytes
//   return to reset values, the label buffer is not cleared
// ----------------------------------------------------------------------------
module dns_name_label_encoder_core
    import dnsle_pkg::*;
#(
    parameter int MAX_LABEL = 62
) (
    input  logic              aclk,
    input  logic              aresetn,
    // configuration: max_bytes write
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [BYTE_W-1:0] cfg_data,
    // input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,   // [7:0] char_byte
    input  logic [0:0]        s_tuser,   // [0] op (0 character, 1 end of name)
    // result stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,   // [7:0] out_byte
    output logic              m_tlast,   // last byte caused by one input transfer
    output logic [0:0]        m_tuser    // [0] overflow
);

    // buffer address and label length widths
    localparam int AW = (MAX_LABEL > 1) ? $clog2(MAX_LABEL) : 1;
    localparam int LW = $clog2(MAX_LABEL + 1);

    logic [BYTE_W-1:0] max_bytes_reg;
    logic [BYTE_W-1:0] max_bytes_next;

    logic              seq_out_valid;
    logic              seq_out_ready;
    out_item_t         seq_out_item;

    logic              ram_wr_en;
    logic [AW-1:0]     ram_wr_addr;
    logic [BYTE_W-1:0] ram_wr_data;
    logic              ram_rd_en;
    logic [AW-1:0]     ram_rd_addr;
    logic [BYTE_W-1:0] ram_rd_data;

    // configuration is always taken; the user must write it only while idle, the block does not enforce this
    assign cfg_ready = 1'b1;

    always_comb begin
        max_bytes_next = max_bytes_reg;
        if (cfg_valid && cfg_ready) begin
            max_bytes_next = cfg_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_bytes_reg <= MAX_BYTES_RESET;
        end else begin
            max_bytes_reg <= max_bytes_next;
        end
    end

    // sequencer: buffering, label readback, byte limit and root byte
    dnsle_seq #(
        .MAX_LABEL (MAX_LABEL),
        .AW        (AW),
        .LW        (LW)
    ) u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_op       (s_tuser[0]),
        .in_char     (s_tdata),
        .max_bytes   (max_bytes_reg),
        .out_valid   (seq_out_valid),
        .out_ready   (seq_out_ready),
        .out_item    (seq_out_item),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    // label character buffer
    dnsle_label_ram #(
        .DEPTH (MAX_LABEL),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // output register toward the result stream
    dnsle_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (seq_out_valid),
        .in_ready (seq_out_ready),
        .in_item  (seq_out_item),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

// File: tb/sv/dnsle_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dnsle_tb_pkg
// expected wire bytes of the dns name label encoder, kept per input transfer
// and compared against every result transfer
// ----------------------------------------------------------------------------
package dnsle_tb_pkg;

    import dnsle_pkg::*;

    localparam int LABEL_DEPTH = 62;

    class label_encoding_checker;

        logic [BYTE_W-1:0] label_chars [LABEL_DEPTH];
        int unsigned       label_len = 0;
        int unsigned       bytes_out = 0;
        bit                label_dropped = 1'b0;
        bit                name_open = 1'b0;
        logic [BYTE_W-1:0] max_bytes = MAX_BYTES_RESET;
        out_item_t         wire_bytes_due [$];
        int unsigned       mismatches = 0;

        function void set_max_bytes(input logic [BYTE_W-1:0] value);
            max_bytes = value;
        endfunction

        function int unsigned pending();
            return wire_bytes_due.size();
        endfunction

        function void push_byte(input logic [BYTE_W-1:0] value, input bit ovf);
            out_item_t item;
            item.out_byte = value;
            item.last     = 1'b0;
            item.overflow = ovf;
            wire_bytes_due.push_back(item);
        endfunction

        // length and character bytes stop at max_bytes per name
        function void push_limited(input logic [BYTE_W-1:0] value, input bit ovf);
            if (bytes_out < max_bytes) begin
                push_byte(value, ovf);
                bytes_out++;
            end
        endfunction

        function void close_label(input bit ovf);
            push_limited(BYTE_W'(label_len), ovf);
            for (int i = 0; i < label_len; i++) begin
                push_limited(label_chars[i], ovf);
            end
            label_len     = 0;
            label_dropped = 1'b0;
        endfunction

        function void take_name_input(input logic op, input logic [BYTE_W-1:0] ch);
            bit          ovf;
            int unsigned due_before;
            ovf        = label_dropped;
            due_before = wire_bytes_due.size();
            if (op == OP_CHAR) begin
                name_open = 1'b1;
                if (ch != DOT_CHAR) begin
                    if (label_len < LABEL_DEPTH) begin
                        label_chars[label_len] = ch;
                        label_len++;
                    end else begin
                        label_dropped = 1'b1;
                    end
                    return;
                end
                close_label(ovf);
            end else begin
                if (name_open) begin
                    close_label(ovf);
                end
                push_byte(ROOT_BYTE, ovf);
                label_len     = 0;
                bytes_out     = 0;
                label_dropped = 1'b0;
                name_open     = 1'b0;
            end
            if (wire_bytes_due.size() > due_before) begin
                wire_bytes_due[wire_bytes_due.size()-1].last = 1'b1;
            end
        endfunction

        function void check_wire_byte(input logic [BYTE_W-1:0] out_byte, input logic last,
                                      input logic overflow);
            out_item_t want;
            if (wire_bytes_due.size() == 0) begin
                $error("result with nothing expected: out_byte %02h", out_byte);
                mismatches++;
                return;
            end
            want = wire_bytes_due.pop_front();
            if (out_byte !== want.out_byte) begin
                $error("out_byte mismatch: expected %02h, actual %02h", want.out_byte, out_byte);
                mismatches++;
            end
            if (last !== want.last) begin
                $error("last mismatch: expected %0b, actual %0b", want.last, last);
                mismatches++;
            end
            if (overflow !== want.overflow) begin
                $error("overflow mismatch: expected %0b, actual %0b", want.overflow, overflow);
                mismatches++;
            end
        endfunction

    endclass

endpackage

// File: tb/sv/tb_dns_name_label_encoder_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dns_name_label_encoder_core
// drives dotted names into the label encoder under several max_bytes settings
// and idle patterns, predicts the wire bytes and checks each result transfer
// ----------------------------------------------------------------------------
module tb_dns_name_label_encoder_core;

    import dnsle_pkg::*;
    import dnsle_tb_pkg::*;

    localparam int SETTLE_CYCLES = 4;     // a buffered character may still be in flight
    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off under pressure
    localparam int STALL_LIMIT   = 3000;  // cycles with no transfer before giving up
    localparam int TAIL_CYCLES   = 20;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [BYTE_W-1:0] cfg_data = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [BYTE_W-1:0] s_tdata = '0;   // [7:0] char_byte
    logic [0:0]        s_tuser = '0;   // [0] op
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [BYTE_W-1:0] m_tdata;        // [7:0] out_byte
    logic              m_tlast;
    logic [0:0]        m_tuser;        // [0] overflow

    label_encoding_checker checker_h;

    int          tx_idle_pct = 0;      // only the stimulus process reads this
    int          rx_stall_pct = 0;     // written with nonblocking, read by the receiver
    logic        rx_hold_toggle = 1'b0;
    logic        rx_hold_seen = 1'b0;
    int          rx_hold_left = 0;
    int unsigned items_sent = 0;
    int unsigned quiet_cycles = 0;

    dns_name_label_encoder_core #(
        .MAX_LABEL(LABEL_DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // receiver: random stalls, or a long hold-off started by a toggle from the stimulus
    always @(posedge aclk) begin
        if (rx_hold_toggle != rx_hold_seen) begin
            rx_hold_seen <= rx_hold_toggle;
            rx_hold_left <= HOLD_CYCLES;
            m_tready     <= 1'b0;
        end else if (rx_hold_left != 0) begin
            rx_hold_left <= rx_hold_left - 1;
            m_tready     <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // monitor: values read here are the ones present at the edge
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                checker_h.check_wire_byte(m_tdata, m_tlast, m_tuser[0]);
            end
            if (s_tvalid && s_tready) begin
                checker_h.take_name_input(s_tuser[0], s_tdata);
            end
        end
    end

    // watchdog: any transfer on any channel counts as progress
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // one input transfer, with random idle cycles in front of it
    task automatic send_item(input logic op, input logic [BYTE_W-1:0] ch);
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid   <= 1'b1;
        s_tuser[0] <= op;
        s_tdata    <= ch;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    // sender goes quiet until every expected wire byte has come out
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (checker_h.pending() != 0);
    endtask

    task automatic write_max_bytes(input logic [BYTE_W-1:0] value);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        checker_h.set_max_bytes(value);
    endtask

    function automatic logic [BYTE_W-1:0] label_char();
        logic [BYTE_W-1:0] ch;
        ch = BYTE_W'($urandom_range(255));
        if (ch == DOT_CHAR) begin
            ch = ch ^ 8'h01;
        end
        return ch;
    endfunction

    task automatic send_label(input int len);
        for (int i = 0; i < len; i++) begin
            send_item(OP_CHAR, label_char());
        end
    endtask

    // mostly well-formed names with random labels, the rest loose character noise
    task automatic send_name();
        int nlab;
        int len;
        int pick;
        if ($urandom_range(99) < 80) begin
            nlab = $urandom_range(1, 4);
            if ($urandom_range(9) == 0) begin
                send_item(OP_CHAR, DOT_CHAR);
            end
            for (int l = 0; l < nlab; l++) begin
                pick = $urandom_range(99);
                if (pick < 3) begin
                    len = $urandom_range(60, 66);   // around the buffer size, may drop chars
                end else if (pick < 15) begin
                    len = $urandom_range(9, 20);
                end else begin
                    len = $urandom_range(0, 8);
                end
                send_label(len);
                if (l != nlab - 1 || $urandom_range(9) == 0) begin
                    send_item(OP_CHAR, DOT_CHAR);
                end
            end
        end else begin
            len = $urandom_range(0, 12);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(3) == 0) begin
                    send_item(OP_CHAR, DOT_CHAR);
                end else begin
                    send_item(OP_CHAR, BYTE_W'($urandom_range(255)));
                end
            end
        end
        send_item(OP_END, BYTE_W'($urandom_range(255)));
    endtask

    task automatic run_phase(input logic [BYTE_W-1:0] max_b, input int tx_pct,
                             input int rx_pct, input int n_items);
        int unsigned stop_at;
        write_max_bytes(max_b);
        tx_idle_pct  = tx_pct;
        rx_stall_pct <= rx_pct;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at) begin
            send_name();
        end
    endtask

    initial begin
        checker_h = new();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed names at full byte budget, no idling
        write_max_bytes(8'd255);
        send_item(OP_END, 8'hFF);                   // empty name, root byte only
        send_item(OP_CHAR, DOT_CHAR);               // lone leading dot
        send_item(OP_END, 8'h00);
        send_item(OP_CHAR, 8'h00);                  // zero byte is a plain character
        send_item(OP_CHAR, 8'hFF);
        send_item(OP_CHAR, DOT_CHAR);
        send_item(OP_CHAR, DOT_CHAR);               // doubled dot, empty label
        send_item(OP_CHAR, 8'h41);
        send_item(OP_CHAR, DOT_CHAR);               // trailing dot, extra zero length
        send_item(OP_END, 8'h5A);
        send_item(OP_CHAR, 8'h7F);
        send_item(OP_CHAR, 8'h80);
        send_item(OP_CHAR, 8'h55);
        send_item(OP_CHAR, 8'hAA);
        send_item(OP_END, 8'hA5);

        // byte limit hit inside the first label, second label fully skipped
        write_max_bytes(8'd2);
        send_item(OP_CHAR, 8'h61);
        send_item(OP_CHAR, 8'h62);
        send_item(OP_CHAR, 8'h63);
        send_item(OP_CHAR, DOT_CHAR);
        send_item(OP_CHAR, 8'h64);
        send_item(OP_END, 8'h00);

        // random names over several budgets and idle patterns
        run_phase(8'd3, 0, 0, 4);
        run_phase(8'd1, 46, 0, 4);
        run_phase(8'd0, 0, 46, 4);
        run_phase(8'd255, 37, 37, 4);

        // pressure: receiver holds off while names keep coming, input must stall
        write_max_bytes(8'd200);
        tx_idle_pct  = 0;
        rx_stall_pct <= 0;
        rx_hold_toggle <= ~rx_hold_toggle;
        send_label(3);
        send_item(OP_CHAR, DOT_CHAR);
        send_label(63);                             // one character beyond the buffer
        send_item(OP_CHAR, DOT_CHAR);
        send_item(OP_END, 8'h3C);
        send_item(OP_CHAR, DOT_CHAR);
        send_item(OP_END, 8'hC3);

        wait_drained();                             // sender pause until all bytes are out
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (checker_h.mismatches == 0 && checker_h.pending() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/dnsle_pkg.sv
rtl/core/dnsle_label_ram.sv
rtl/core/dnsle_out_reg.sv
rtl/core/dnsle_seq.sv
rtl/core/dns_name_label_encoder_core.sv
tb/sv/dnsle_tb_pkg.sv
tb/sv/tb_dns_name_label_encoder_core.sv
